/* rtl/core/i2c_master_message_sequencer_assert.svh */
// Assertion macros for the I2C master message sequencer.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef I2C_MASTER_MESSAGE_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_MESSAGE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, masked while in reset
`define I2CMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cms: same-cycle check failed");

// Next-cycle implication, masked while in reset
`define I2CMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cms: next-cycle check failed");

`endif

/* rtl/core/i2cms_pkg.sv */
// Shared types and constants of the I2C master message sequencer.
// No dependencies; used by the interfaces and every RTL module.
package i2cms_pkg;

  // Largest message the sequencer handles; longer lengths are clamped
  localparam int MAX_MESSAGE_BYTES = 255;

  localparam int ADDR_W = 7;
  localparam int LEN_W  = 8;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 9;
  localparam int CFG_W  = 8;
  localparam int CIDX_W = 2;

  localparam int MAX_LEN_CLAMP = (MAX_MESSAGE_BYTES > 255) ? 255 : MAX_MESSAGE_BYTES;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LEN_CLAMP);

  // Position code of the address phase (minus one)
  localparam logic [POS_W-1:0] POS_ADDR = '1;

  // Status bits
  localparam logic [BYTE_W-1:0] ST_AL   = 8'h08;
  localparam logic [BYTE_W-1:0] ST_NACK = 8'h04;
  localparam logic [BYTE_W-1:0] ST_DONE = 8'h20;

  // Request kinds
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_IRQ   = 1'b1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_SLAVE_ADDRESS  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_READ_MODE      = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MESSAGE_LENGTH = 2'd2;

  typedef enum logic [2:0] {
    OP_BEGIN     = 3'd0,
    OP_SEND      = 3'd1,
    OP_SEND_STOP = 3'd2,
    OP_SEND_RECV = 3'd3,
    OP_RECV      = 3'd4,
    OP_RECV_STOP = 3'd5,
    OP_ABORT     = 3'd6
  } bus_op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] slave_address;
    logic              read_mode;
    logic [LEN_W-1:0]  message_length;
  } cfg_t;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] status_byte;
    logic [BYTE_W-1:0] tx_byte;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    bus_op_t           bus_op;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_index;
    logic              store_valid;
    logic              done_res;
    logic              failed;
    logic [BYTE_W-1:0] status_seen;
  } result_t;

endpackage

/* rtl/core/i2cms_in_if.sv */
// Request channel of the I2C master message sequencer (valid/ready).
// Depends on i2cms_pkg for field widths.
interface i2cms_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [i2cms_pkg::BYTE_W-1:0]     status_byte;
  logic [i2cms_pkg::BYTE_W-1:0]     tx_byte;
  logic [i2cms_pkg::BYTE_W-1:0]     rx_byte;

  modport source (output valid, action, status_byte, tx_byte, rx_byte, input ready);
  modport sink   (input valid, action, status_byte, tx_byte, rx_byte, output ready);
endinterface

/* rtl/core/i2cms_out_if.sv */
// Result channel of the I2C master message sequencer (valid/ready).
// Depends on i2cms_pkg for field types and widths.
interface i2cms_out_if;
  logic                             valid;
  logic                             ready;
  i2cms_pkg::bus_op_t               bus_op;
  logic [i2cms_pkg::BYTE_W-1:0]     data_byte;
  logic [i2cms_pkg::BYTE_W-1:0]     byte_index;
  logic                             store_valid;
  logic                             done_res;
  logic                             failed;
  logic [i2cms_pkg::BYTE_W-1:0]     status_seen;

  modport source (output valid, bus_op, data_byte, byte_index, store_valid, done_res,
                  failed, status_seen, input ready);
  modport sink   (input valid, bus_op, data_byte, byte_index, store_valid, done_res,
                  failed, status_seen, output ready);
endinterface

/* rtl/core/i2cms_cfg_regs.sv */
// Configuration registers: slave address, direction and message length.
// Depends on i2cms_pkg.
module i2cms_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [i2cms_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [i2cms_pkg::CFG_W-1:0]    cfg_wdata,
  output i2cms_pkg::cfg_t                cfg
);
  import i2cms_pkg::*;

  cfg_t cfg_r;

  // Register write decode; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDRESS:  cfg_r.slave_address  <= cfg_wdata[ADDR_W-1:0];
        CFG_READ_MODE:      cfg_r.read_mode      <= cfg_wdata[0];
        CFG_MESSAGE_LENGTH: cfg_r.message_length <= cfg_wdata[LEN_W-1:0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/i2cms_step.sv */
// Decision logic for one request: next position, status and the result.
// Depends on i2cms_pkg; purely combinational.
module i2cms_step (
  input  i2cms_pkg::item_t                 item,
  input  i2cms_pkg::cfg_t                  cfg,
  input  logic [i2cms_pkg::POS_W-1:0]      position,
  input  logic [i2cms_pkg::BYTE_W-1:0]     status_acc,
  output i2cms_pkg::result_t               res,
  output logic [i2cms_pkg::POS_W-1:0]      position_nxt,
  output logic [i2cms_pkg::BYTE_W-1:0]     status_nxt
);
  import i2cms_pkg::*;

  logic [LEN_W-1:0]  eff_len;
  logic [POS_W-1:0]  len_pos;
  logic [POS_W-1:0]  last_pos;
  logic              at_addr;
  logic              at_end;
  logic              at_last;
  logic              abort;
  logic [BYTE_W-1:0] sacc;

  // Length clamp and position compares
  assign eff_len  = (cfg.message_length > MAX_LEN) ? MAX_LEN : cfg.message_length;
  assign len_pos  = {1'b0, eff_len};
  assign last_pos = len_pos - POS_W'(1);
  assign at_addr  = (position == POS_ADDR);
  assign at_end   = (position == len_pos);
  assign at_last  = (position == last_pos);
  assign abort    = |(item.status_byte & (ST_AL | ST_NACK));
  assign sacc     = status_acc | item.status_byte;

  // Step selection: start, abort, dummy read, address, write byte, read byte
  always_comb begin
    res          = '0;
    res.bus_op   = OP_BEGIN;
    position_nxt = position;
    status_nxt   = status_acc;
    if (item.action == ACT_START) begin
      status_nxt   = '0;
      position_nxt = POS_ADDR;
    end else begin
      if (abort) begin
        res.bus_op   = OP_ABORT;
        res.done_res = 1'b1;
        res.failed   = 1'b1;
      end else if (at_end) begin
        // dummy read closes a read; the byte is dropped
        res.bus_op   = OP_RECV;
        res.done_res = 1'b1;
      end else begin
        if (at_addr || !cfg.read_mode) begin
          res.data_byte = at_addr ? {cfg.slave_address, cfg.read_mode} : item.tx_byte;
          if (cfg.read_mode) begin
            res.bus_op = OP_SEND_RECV;
          end else if (at_last) begin
            res.bus_op   = OP_SEND_STOP;
            res.done_res = 1'b1;
          end else begin
            res.bus_op = OP_SEND;
          end
        end else begin
          res.bus_op      = at_last ? OP_RECV_STOP : OP_RECV;
          res.data_byte   = item.rx_byte;
          res.byte_index  = position[BYTE_W-1:0];
          res.store_valid = 1'b1;
        end
        position_nxt = position + POS_W'(1);
      end
      status_nxt = sacc | (res.done_res ? ST_DONE : '0);
    end
    res.status_seen = status_nxt;
  end

endmodule

/* rtl/core/i2c_master_message_sequencer.sv */
// Top level of the I2C master message sequencer: request register, step
// logic, message state and result register. Depends on i2cms_pkg,
// i2cms_in_if, i2cms_out_if, i2cms_cfg_regs, i2cms_step and the assert header.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  in_ch    | in        | valid / ready      | action, status_byte, tx_byte, rx_byte
//  out_ch   | out       | valid / ready      | bus_op .. status_seen, one per request
//  cfg_*    | in        | cfg_we, no ready   | cfg_index, cfg_wdata
//
// One request per clock while out_ch is ready; stages: request register, then
// result register. Position and accumulated status update as a request moves
// from the request register into the result register. A stalled result holds
// in the result register while one more request waits in the request
// register. Synchronous active-low reset puts position at the address phase.
`include "i2c_master_message_sequencer_assert.svh"

module i2c_master_message_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  i2cms_in_if.sink                       in_ch,
  i2cms_out_if.source                    out_ch,
  input  logic                           cfg_we,
  input  logic [i2cms_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [i2cms_pkg::CFG_W-1:0]    cfg_wdata
);
  import i2cms_pkg::*;

  cfg_t              cfg;
  item_t             in_item;
  item_t             s1_item_r;
  logic              s1_valid_r;
  result_t           step_res;
  result_t           out_res_r;
  logic              out_valid_r;
  logic [POS_W-1:0]  position_r;
  logic [POS_W-1:0]  position_nxt;
  logic [BYTE_W-1:0] status_r;
  logic [BYTE_W-1:0] status_nxt;
  logic              out_free;
  logic              s1_adv;
  logic              in_ready;
  logic              in_acc;

  i2cms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  i2cms_step u_step (
    .item         (s1_item_r),
    .cfg          (cfg),
    .position     (position_r),
    .status_acc   (status_r),
    .res          (step_res),
    .position_nxt (position_nxt),
    .status_nxt   (status_nxt)
  );

  // Handshake between the two register stages
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_acc   = in_ch.valid && in_ready;

  assign in_item.action      = in_ch.action;
  assign in_item.status_byte = in_ch.status_byte;
  assign in_item.tx_byte     = in_ch.tx_byte;
  assign in_item.rx_byte     = in_ch.rx_byte;

  // Control state and message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      position_r  <= POS_ADDR;
      status_r    <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        position_r <= position_nxt;
        status_r   <= status_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.bus_op      = out_res_r.bus_op;
  assign out_ch.data_byte   = out_res_r.data_byte;
  assign out_ch.byte_index  = out_res_r.byte_index;
  assign out_ch.store_valid = out_res_r.store_valid;
  assign out_ch.done_res    = out_res_r.done_res;
  assign out_ch.failed      = out_res_r.failed;
  assign out_ch.status_seen = out_res_r.status_seen;

  // A stored byte only comes with a receive
  `I2CMS_ASSERT_NOW(a_store_is_recv, out_valid_r && out_res_r.store_valid,
    out_res_r.bus_op == OP_RECV || out_res_r.bus_op == OP_RECV_STOP)
  // A failure is always an abort that finishes the message
  `I2CMS_ASSERT_NOW(a_fail_is_abort, out_valid_r && out_res_r.failed,
    out_res_r.bus_op == OP_ABORT && out_res_r.done_res)
  // Finishing reports the software-done bit
  `I2CMS_ASSERT_NOW(a_done_flags, out_valid_r && out_res_r.done_res,
    (out_res_r.status_seen & ST_DONE) == ST_DONE)
  // A waiting request is never dropped
  `I2CMS_ASSERT_NEXT(a_s1_held, s1_valid_r && !s1_adv, s1_valid_r)
  // A start request returns the position to the address phase
  `I2CMS_ASSERT_NEXT(a_start_pos, s1_adv && s1_item_r.action == ACT_START,
    position_r == POS_ADDR && status_r == '0)

endmodule
